FILE: rtl/core/ipre_pkg.sv
package ipre_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_PREDICTOR_MODE  = 3'd0;
    localparam logic [2:0] REG_FRAME_WIDTH     = 3'd1;
    localparam logic [2:0] REG_FRAME_HEIGHT    = 3'd2;
    localparam logic [2:0] REG_ADAPTIVE_ENABLE = 3'd3;
    localparam logic [2:0] REG_BLOCK_SIZE      = 3'd4;

    // predictor codes
    localparam logic [2:0] PRED_LEFT      = 3'd0;
    localparam logic [2:0] PRED_TOP       = 3'd1;
    localparam logic [2:0] PRED_CORNER    = 3'd2;
    localparam logic [2:0] PRED_PLANAR    = 3'd3;
    localparam logic [2:0] PRED_LEFT_HALF = 3'd4;
    localparam logic [2:0] PRED_TOP_HALF  = 3'd5;
    localparam logic [2:0] PRED_AVERAGE   = 3'd6;
    localparam logic [2:0] PRED_MEDIAN    = 3'd7;

    // plane codes
    localparam logic [1:0] PLANE_Y = 2'd0;
    localparam logic [1:0] PLANE_U = 2'd1;
    localparam logic [1:0] PLANE_V = 2'd2;

    localparam int MAX_HEIGHT  = 4096;
    localparam int FRAC_BITS   = 24;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam logic [9:0] M_MIN = 10'd2;
    localparam logic [9:0] M_MAX = 10'd1023;

    typedef struct packed {
        logic [2:0]  predictor_mode;
        logic [12:0] frame_width;
        logic [12:0] frame_height;
        logic        adaptive_enable;
        logic [15:0] block_size;
    } ipre_cfg_t;

    // one classified sample, front to back
    typedef struct packed {
        logic [9:0]  residual;
        logic [1:0]  plane;
        logic        need_m;
        logic [26:0] sum;
        logic [15:0] n;
        logic        frame_end;
    } ipre_rec_t;

    // halve with truncation toward zero
    function automatic logic signed [10:0] half_tz(input logic signed [10:0] v);
        logic [10:0] t;
        begin
            t = v + 11'(v[10]);
            return $signed(t) >>> 1;
        end
    endfunction

    function automatic logic signed [10:0] predict(input logic signed [10:0] l,
                                                   input logic signed [10:0] t,
                                                   input logic signed [10:0] tl,
                                                   input logic [2:0] mode);
        logic signed [10:0] mx;
        logic signed [10:0] mn;
        logic signed [10:0] p;
        begin
            mx = (l > t) ? l : t;
            mn = (l < t) ? l : t;
            case (mode)
                PRED_LEFT:      p = l;
                PRED_TOP:       p = t;
                PRED_CORNER:    p = tl;
                PRED_PLANAR:    p = l + t - tl;
                PRED_LEFT_HALF: p = l + half_tz(t - tl);
                PRED_TOP_HALF:  p = t + half_tz(l - tl);
                PRED_AVERAGE:   p = half_tz(l + t);
                default: begin
                    if (tl >= mx) p = mn;
                    else if (tl <= mn) p = mx;
                    else p = l + t - tl;
                end
            endcase
            return p;
        end
    endfunction

endpackage

FILE: rtl/core/ipre_front.sv
module ipre_front #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ipre_pkg::ipre_cfg_t cfg,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_sample,
    input  logic                q_full,
    output logic                q_push,
    output ipre_pkg::ipre_rec_t q_data
);
    import ipre_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = CW + 1;
    localparam int HW = (CW > 1) ? CW - 1 : 1;
    localparam int HALF_W = MAX_WIDTH / 2;

    typedef enum logic [1:0] {
        F_IDLE = 2'b01,
        F_CALC = 2'b10
    } front_state_t;

    front_state_t state_reg, state_next;

    logic [7:0] luma_mem [MAX_WIDTH];
    logic [7:0] cb_mem [HALF_W];
    logic [7:0] cr_mem [HALF_W];
    logic [7:0] y_rd_reg, u_rd_reg, v_rd_reg;

    logic [7:0]    left_reg [3];
    logic [7:0]    corner_reg [3];
    logic [7:0]    sample_reg;
    logic [CW-1:0] col_count_reg, col_count_next;
    logic [11:0]   row_count_reg, row_count_next;
    logic [1:0]    phase_reg, phase_next;
    logic [26:0]   sum_reg, sum_next;
    logic [15:0]   block_count_reg, block_count_next;

    logic [13:0]   fw_ext;
    logic [WW-1:0] w_eff, uvw;
    logic [12:0]   h_eff, uvh;
    logic [1:0]    plane;
    logic          in_line;
    logic [7:0]    above;
    logic signed [10:0] l_v, t_v, tl_v, res11, dbl;
    logic [9:0]    mapped;
    logic [26:0]   sum_add;
    logic          finish, upd, fend;
    logic [15:0]   n_eff, bc_inc;

    // clamp the frame size
    always_comb begin
        fw_ext = {1'b0, cfg.frame_width};
        if (fw_ext == 14'd0) w_eff = WW'(1);
        else if (fw_ext > 14'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
        else w_eff = WW'(fw_ext);
        if (cfg.frame_height == 13'd0) h_eff = 13'd1;
        else if (cfg.frame_height > 13'(MAX_HEIGHT)) h_eff = 13'(MAX_HEIGHT);
        else h_eff = cfg.frame_height;
        uvw = w_eff >> 1;
        uvh = h_eff >> 1;
    end

    assign s_tready = (state_reg == F_IDLE) && !q_full;

    // row-above reads, registered; line buffer writes in the calc state
    always_ff @(posedge aclk) begin
        y_rd_reg <= luma_mem[col_count_reg];
        u_rd_reg <= cb_mem[HW'(col_count_reg)];
        v_rd_reg <= cr_mem[HW'(col_count_reg)];
        if (state_reg == F_CALC && in_line) begin
            case (plane)
                PLANE_U: cb_mem[HW'(col_count_reg)] <= sample_reg;
                PLANE_V: cr_mem[HW'(col_count_reg)] <= sample_reg;
                default: luma_mem[col_count_reg] <= sample_reg;
            endcase
        end
    end

    // neighbours and residual
    always_comb begin
        plane = (phase_reg == 2'd3) ? PLANE_Y : phase_reg;
        case (plane)
            PLANE_U: begin
                above = u_rd_reg;
                in_line = ({1'b0, col_count_reg} < WW'(HALF_W));
            end
            PLANE_V: begin
                above = v_rd_reg;
                in_line = ({1'b0, col_count_reg} < WW'(HALF_W));
            end
            default: begin
                above = y_rd_reg;
                in_line = 1'b1;
            end
        endcase
        l_v  = (col_count_reg != '0) ? $signed({3'b0, left_reg[plane]}) : 11'sd0;
        t_v  = (row_count_reg != '0 && in_line) ? $signed({3'b0, above}) : 11'sd0;
        tl_v = (row_count_reg != '0 && col_count_reg != '0 && in_line)
               ? $signed({3'b0, corner_reg[plane]}) : 11'sd0;
        res11 = $signed({3'b0, sample_reg}) - predict(l_v, t_v, tl_v, cfg.predictor_mode);
        dbl = res11 <<< 1;
        mapped = (res11 > 11'sd0) ? 10'(dbl - 11'sd1) : 10'(-dbl);
        sum_add = (cfg.adaptive_enable && plane == PLANE_Y) ? sum_reg + 27'(mapped) : sum_reg;
    end

    // position, phase and block bookkeeping
    always_comb begin
        case (plane)
            PLANE_Y: begin
                finish = !(13'(row_count_reg) < uvh && {1'b0, col_count_reg} < uvw);
                phase_next = finish ? PLANE_Y : PLANE_U;
            end
            PLANE_U: begin
                finish = 1'b0;
                phase_next = PLANE_V;
            end
            default: begin
                finish = 1'b1;
                phase_next = PLANE_Y;
            end
        endcase
        n_eff = (cfg.block_size == 16'd0) ? 16'd1 : cfg.block_size;
        bc_inc = block_count_reg + 16'd1;
        upd = finish && cfg.adaptive_enable && (bc_inc >= n_eff || bc_inc == 16'd0);
        block_count_next = block_count_reg;
        if (finish && cfg.adaptive_enable) block_count_next = upd ? 16'd0 : bc_inc;
        sum_next = upd ? 27'd0 : sum_add;
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        fend = 1'b0;
        if (finish) begin
            if ({1'b0, col_count_reg} + WW'(1) >= w_eff) begin
                col_count_next = '0;
                if (13'(row_count_reg) + 13'd1 >= h_eff) begin
                    row_count_next = '0;
                    fend = 1'b1;
                    sum_next = 27'd0;
                    block_count_next = 16'd0;
                end else begin
                    row_count_next = row_count_reg + 12'd1;
                end
            end else begin
                col_count_next = col_count_reg + CW'(1);
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE: if (s_tvalid && s_tready) state_next = F_CALC;
            F_CALC: state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    assign q_push           = (state_reg == F_CALC);
    assign q_data.residual  = res11[9:0];
    assign q_data.plane     = plane;
    assign q_data.need_m    = upd;
    assign q_data.sum       = sum_add;
    assign q_data.n         = n_eff;
    assign q_data.frame_end = fend;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= F_IDLE;
            col_count_reg   <= '0;
            row_count_reg   <= '0;
            phase_reg       <= PLANE_Y;
            sum_reg         <= '0;
            block_count_reg <= '0;
            for (int i = 0; i < 3; i++) begin
                left_reg[i]   <= '0;
                corner_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (s_tvalid && s_tready) sample_reg <= s_sample;
            if (state_reg == F_CALC) begin
                col_count_reg   <= col_count_next;
                row_count_reg   <= row_count_next;
                phase_reg       <= phase_next;
                sum_reg         <= sum_next;
                block_count_reg <= block_count_next;
                left_reg[plane] <= sample_reg;
                if (in_line) corner_reg[plane] <= above;
            end
        end
    end

endmodule

FILE: rtl/core/ipre_queue.sv
module ipre_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  ipre_pkg::ipre_rec_t push_data,
    input  logic                pop,
    output ipre_pkg::ipre_rec_t pop_data,
    output logic                full,
    output logic                empty
);
    import ipre_pkg::*;

    ipre_rec_t        entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign full     = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge aclk) begin
        if (push && !full) entry_reg[wr_ptr_reg] <= push_data;
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push && !full) wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop && !empty) rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            case ({push && !full, pop && !empty})
                2'b10:   count_reg <= count_reg + (QPTR_W+1)'(1);
                2'b01:   count_reg <= count_reg - (QPTR_W+1)'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

FILE: rtl/core/ipre_back.sv
module ipre_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_empty,
    input  ipre_pkg::ipre_rec_t q_data,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [9:0]          out_residual,
    output logic [1:0]          out_plane,
    output logic                out_m_update,
    output logic [9:0]          out_new_m,
    output logic                out_frame_end
);
    import ipre_pkg::*;

    typedef enum logic [4:0] {
        B_IDLE = 5'b00001,
        B_NORM = 5'b00010,
        B_SQR  = 5'b00100,
        B_DIV  = 5'b01000,
        B_HOLD = 5'b10000
    } back_state_t;

    back_state_t state_reg;
    ipre_rec_t   rec_reg;
    logic [31:0] z_reg;
    logic [4:0]  cnt_reg;
    logic [4:0]  iter_reg;
    logic [23:0] frac_reg;
    logic        second_reg;
    logic [28:0] log_a_reg;
    logic [28:0] l_reg;
    logic [24:0] num_reg;
    logic [24:0] quo_reg;
    logic [29:0] rem_reg;
    logic [9:0]  m_reg;
    logic        out_valid_reg;

    logic        out_free;
    logic [61:0] prod;
    logic [31:0] sq;
    logic [28:0] log_v;
    logic [29:0] rem_shift;
    logic [25:0] m_round;

    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign q_pop    = (state_reg == B_IDLE) && !q_empty && (q_data.need_m || out_free);

    // one squaring step of the log fraction, plus the log value, divide shift and rounded m
    always_comb begin
        prod  = 62'(z_reg[30:0]) * 62'(z_reg[30:0]);
        sq    = prod[61:30];
        log_v = {5'(5'd30 - cnt_reg), frac_reg};
        rem_shift = {rem_reg[28:0], num_reg[24]};
        m_round = 26'(quo_reg) + 26'(rem_reg != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && m_tready) out_valid_reg <= 1'b0;
            case (state_reg)
                // take the next beat; plain residuals go straight out, a zero sum holds M_MIN
                B_IDLE: begin
                    if (q_pop) begin
                        rec_reg <= q_data;
                        if (!q_data.need_m) begin
                            out_valid_reg <= 1'b1;
                            out_residual  <= q_data.residual;
                            out_plane     <= q_data.plane;
                            out_m_update  <= 1'b0;
                            out_new_m     <= 10'd0;
                            out_frame_end <= q_data.frame_end;
                        end else if (q_data.sum == 27'd0) begin
                            m_reg     <= M_MIN;
                            state_reg <= B_HOLD;
                        end else begin
                            z_reg      <= 32'(q_data.sum) + 32'(q_data.n);
                            cnt_reg    <= 5'd0;
                            second_reg <= 1'b0;
                            state_reg  <= B_NORM;
                        end
                    end
                end
                // normalize to a Q30 mantissa one bit per cycle
                B_NORM: begin
                    if (!z_reg[30]) begin
                        z_reg   <= z_reg << 1;
                        cnt_reg <= cnt_reg + 5'd1;
                    end else begin
                        iter_reg  <= 5'd0;
                        frac_reg  <= 24'd0;
                        state_reg <= B_SQR;
                    end
                end
                // fraction bits by repeated squaring
                B_SQR: begin
                    if (iter_reg == 5'(FRAC_BITS)) begin
                        if (!second_reg) begin
                            log_a_reg  <= log_v;
                            second_reg <= 1'b1;
                            z_reg      <= 32'(rec_reg.sum);
                            cnt_reg    <= 5'd0;
                            state_reg  <= B_NORM;
                        end else if (log_a_reg <= log_v) begin
                            m_reg     <= M_MAX;
                            state_reg <= B_HOLD;
                        end else begin
                            l_reg     <= log_a_reg - log_v;
                            num_reg   <= 25'd1 << FRAC_BITS;
                            quo_reg   <= 25'd0;
                            rem_reg   <= 30'd0;
                            iter_reg  <= 5'd0;
                            state_reg <= B_DIV;
                        end
                    end else begin
                        iter_reg <= iter_reg + 5'd1;
                        if (sq[31]) begin
                            z_reg    <= sq >> 1;
                            frac_reg <= {frac_reg[22:0], 1'b1};
                        end else begin
                            z_reg    <= sq;
                            frac_reg <= {frac_reg[22:0], 1'b0};
                        end
                    end
                end
                // restoring divide, one quotient bit per cycle
                B_DIV: begin
                    if (iter_reg == 5'(FRAC_BITS + 1)) begin
                        if (m_round >= 26'(M_MAX)) m_reg <= M_MAX;
                        else if (m_round < 26'(M_MIN)) m_reg <= M_MIN;
                        else m_reg <= 10'(m_round);
                        state_reg <= B_HOLD;
                    end else begin
                        iter_reg <= iter_reg + 5'd1;
                        num_reg  <= num_reg << 1;
                        if (rem_shift >= {1'b0, l_reg}) begin
                            rem_reg <= rem_shift - {1'b0, l_reg};
                            quo_reg <= {quo_reg[23:0], 1'b1};
                        end else begin
                            rem_reg <= rem_shift;
                            quo_reg <= {quo_reg[23:0], 1'b0};
                        end
                    end
                end
                // deliver the beat carrying the new m
                B_HOLD: begin
                    if (out_free) begin
                        out_valid_reg <= 1'b1;
                        out_residual  <= rec_reg.residual;
                        out_plane     <= rec_reg.plane;
                        out_m_update  <= 1'b1;
                        out_new_m     <= m_reg;
                        out_frame_end <= rec_reg.frame_end;
                        state_reg     <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/core/intra_predictive_residual_encoder_top.sv
// each sample passes the front end in order: line buffer read, then predict
// plain residuals leave via the queue; the front end takes no new sample until
// it has pushed the last one; a beat that closes an estimation block waits in
// the back end for two serial log2 passes and a bit-serial divide
// aresetn (synchronous, active low) clears position, phase, sums, queue and
// configuration registers to their defaults; line buffers are not cleared
module intra_predictive_residual_encoder_top #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // sample_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // residual, new_m, zero fill
    output logic [2:0]  m_tuser,   // plane, m_update
    output logic        m_tlast    // frame_end
);
    import ipre_pkg::*;

    ipre_cfg_t cfg_reg;
    ipre_rec_t push_data, pop_data;
    logic      push, pop, q_full, q_empty;
    logic [9:0] residual, new_m;
    logic [1:0] plane;
    logic       m_update, frame_end;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.predictor_mode  <= PRED_LEFT;
            cfg_reg.frame_width     <= 13'd352;
            cfg_reg.frame_height    <= 13'd288;
            cfg_reg.adaptive_enable <= 1'b0;
            cfg_reg.block_size      <= 16'd16;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_PREDICTOR_MODE:  cfg_reg.predictor_mode  <= cfg_wr_data[2:0];
                REG_FRAME_WIDTH:     cfg_reg.frame_width     <= cfg_wr_data[12:0];
                REG_FRAME_HEIGHT:    cfg_reg.frame_height    <= cfg_wr_data[12:0];
                REG_ADAPTIVE_ENABLE: cfg_reg.adaptive_enable <= cfg_wr_data[0];
                REG_BLOCK_SIZE:      cfg_reg.block_size      <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    ipre_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_sample (s_tdata),
        .q_full   (q_full),
        .q_push   (push),
        .q_data   (push_data)
    );

    ipre_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    ipre_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_empty       (q_empty),
        .q_data        (pop_data),
        .q_pop         (pop),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .out_residual  (residual),
        .out_plane     (plane),
        .out_m_update  (m_update),
        .out_new_m     (new_m),
        .out_frame_end (frame_end)
    );

    // result beat packing
    assign m_tdata = {4'd0, new_m, residual};
    assign m_tuser = {m_update, plane};
    assign m_tlast = frame_end;

endmodule
